/* rtl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Sizes, command and status codes, state encoding and ring slot helpers for
// the bounded double-ended queue with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int CAPACITY   = 16;
    localparam int WORD_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int SUM_W      = IDX_W + 1;
    localparam int OP_W       = 4;
    localparam int STATUS_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_POP_BACK   = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_READ_FRONT = 4'd4,
        OP_READ_BACK  = 4'd5,
        OP_SEARCH     = 4'd6,
        OP_REMOVE     = 4'd7,
        OP_REVERSE    = 4'd8,
        OP_CLEAR      = 4'd9
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    // sum is always below twice the capacity
    function automatic logic [IDX_W-1:0] wrap_slot(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] cap;
        cap = SUM_W'(CAPACITY);
        if (sum >= cap) begin
            return IDX_W'(sum - cap);
        end
        return IDX_W'(sum);
    endfunction

    // physical slot of logical position i counted from the front
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                 input logic [CNT_W-1:0] count,
                                                 input logic             rev,
                                                 input logic [CNT_W-1:0] i);
        logic [CNT_W-1:0] off;
        off = rev ? (count - CNT_W'(1) - i) : i;
        return wrap_slot(SUM_W'(front) + SUM_W'(off));
    endfunction

endpackage

/* rtl/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bounded_deque_with_search.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue held in a ring RAM, with search and remove of the
// first matching element. Reverse flips a direction flag and moves no data.
// ----------------------------------------------------------------------------
//  channel   direction  ports                                          beat
//  s_        in         s_opcode, s_data_word                          command
//  m_        out        m_read_word, m_status, m_found, m_position,    result
//                       m_occupancy
//
//  push, pop, read, reverse, clear and other codes: accepted in idle, answered from finish
//  search: walks from the front to the first match, or over every entry on a miss
//  remove: search walk, then later entries shift down; the single RAM read port walks one entry a cycle
//  one command at a time; the result register frees the input while m_ waits
//  reset (synchronous, active low) empties the queue; no RAM clearing pass
// ----------------------------------------------------------------------------
module bounded_deque_with_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bdq_pkg::OP_W-1:0]            s_opcode,
    input  logic [bdq_pkg::WORD_WIDTH-1:0]      s_data_word,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bdq_pkg::WORD_WIDTH-1:0]      m_read_word,
    output logic [bdq_pkg::STATUS_W-1:0]        m_status,
    output logic                                m_found,
    output logic [bdq_pkg::IDX_W-1:0]           m_position,
    output logic [bdq_pkg::CNT_W-1:0]           m_occupancy
);

    localparam int IDX_W = bdq_pkg::IDX_W;
    localparam int CNT_W = bdq_pkg::CNT_W;
    localparam int WW    = bdq_pkg::WORD_WIDTH;
    localparam int SUM_W = bdq_pkg::SUM_W;

    bdq_pkg::state_t  state_reg, state_next;
    bdq_pkg::opcode_t op_reg, op_next, op_in;
    bdq_pkg::status_t status_reg, status_next;

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rev_reg, rev_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             found_reg, found_next;
    logic             take_rd_reg, take_rd_next;
    logic [WW-1:0]    data_reg, data_next;

    logic             m_valid_reg;
    logic [WW-1:0]    m_read_word_reg;
    logic [1:0]       m_status_reg;
    logic             m_found_reg;
    logic [IDX_W-1:0] m_position_reg;
    logic [CNT_W-1:0] m_occupancy_reg;

    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [WW-1:0]    ram_wdata, ram_rdata;

    logic             accept, full, empty, hit, more, shift_more, out_load;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W:0]   idx_inc2;
    logic [IDX_W-1:0] front_dec, front_inc;

    assign op_in      = bdq_pkg::opcode_t'(s_opcode);
    assign s_ready    = (state_reg == bdq_pkg::S_IDLE);
    assign accept     = s_valid && s_ready;
    assign full       = (count_reg == CNT_W'(bdq_pkg::CAPACITY));
    assign empty      = (count_reg == '0);
    assign hit        = (ram_rdata == data_reg);
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign idx_inc2   = {1'b0, idx_reg} + (CNT_W+1)'(2);
    assign more       = (idx_inc < count_reg);
    assign shift_more = (idx_inc2 < {1'b0, count_reg});
    assign out_load   = (state_reg == bdq_pkg::S_FINISH) && (!m_valid_reg || m_ready);
    assign front_dec  = bdq_pkg::wrap_slot(SUM_W'(front_reg) + SUM_W'(bdq_pkg::CAPACITY - 1));
    assign front_inc  = bdq_pkg::wrap_slot(SUM_W'(front_reg) + SUM_W'(1));

    bdq_ram #(
        .WIDTH (WW),
        .DEPTH (bdq_pkg::CAPACITY)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bdq_pkg::S_IDLE: begin
                if (accept) begin
                    if ((op_in == bdq_pkg::OP_SEARCH || op_in == bdq_pkg::OP_REMOVE)
                        && !empty) begin
                        state_next = bdq_pkg::S_SCAN;
                    end else begin
                        state_next = bdq_pkg::S_FINISH;
                    end
                end
            end
            bdq_pkg::S_SCAN: begin
                if (hit) begin
                    if (op_reg == bdq_pkg::OP_REMOVE && more) begin
                        state_next = bdq_pkg::S_SHIFT;
                    end else begin
                        state_next = bdq_pkg::S_FINISH;
                    end
                end else if (!more) begin
                    state_next = bdq_pkg::S_FINISH;
                end
            end
            bdq_pkg::S_SHIFT: begin
                if (!shift_more) begin
                    state_next = bdq_pkg::S_FINISH;
                end
            end
            bdq_pkg::S_FINISH: begin
                if (out_load) begin
                    state_next = bdq_pkg::S_IDLE;
                end
            end
            default: state_next = bdq_pkg::S_IDLE;
        endcase
    end

    // ring access and state updates
    always_comb begin
        ram_we       = 1'b0;
        ram_waddr    = front_reg;
        ram_wdata    = data_reg;
        ram_re       = 1'b0;
        ram_raddr    = front_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        rev_next     = rev_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        take_rd_next = take_rd_reg;
        status_next  = status_reg;
        op_next      = op_reg;
        data_next    = data_reg;
        case (state_reg)
            bdq_pkg::S_IDLE: begin
                if (accept) begin
                    op_next      = op_in;
                    data_next    = s_data_word;
                    status_next  = bdq_pkg::STAT_OK;
                    found_next   = 1'b0;
                    pos_next     = '0;
                    take_rd_next = 1'b0;
                    idx_next     = '0;
                    ram_wdata    = s_data_word;
                    case (op_in)
                        bdq_pkg::OP_PUSH_BACK, bdq_pkg::OP_PUSH_FRONT: begin
                            if (full) begin
                                status_next = bdq_pkg::STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                // low end of the ring grows the front pointer down
                                if ((op_in == bdq_pkg::OP_PUSH_FRONT) ^ rev_reg) begin
                                    ram_waddr  = front_dec;
                                    front_next = front_dec;
                                end else begin
                                    ram_waddr = bdq_pkg::wrap_slot(SUM_W'(front_reg)
                                                                   + SUM_W'(count_reg));
                                end
                            end
                        end
                        bdq_pkg::OP_POP_BACK, bdq_pkg::OP_POP_FRONT,
                        bdq_pkg::OP_READ_FRONT, bdq_pkg::OP_READ_BACK: begin
                            if (empty) begin
                                status_next = bdq_pkg::STAT_EMPTY;
                            end else begin
                                ram_re       = 1'b1;
                                take_rd_next = 1'b1;
                                if ((op_in == bdq_pkg::OP_POP_BACK ||
                                     op_in == bdq_pkg::OP_READ_BACK) == rev_reg) begin
                                    ram_raddr = front_reg;
                                    if (op_in == bdq_pkg::OP_POP_BACK ||
                                        op_in == bdq_pkg::OP_POP_FRONT) begin
                                        front_next = front_inc;
                                    end
                                end else begin
                                    ram_raddr = bdq_pkg::wrap_slot(SUM_W'(front_reg)
                                                + SUM_W'(count_reg - CNT_W'(1)));
                                end
                                if (op_in == bdq_pkg::OP_POP_BACK ||
                                    op_in == bdq_pkg::OP_POP_FRONT) begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        bdq_pkg::OP_SEARCH, bdq_pkg::OP_REMOVE: begin
                            if (empty) begin
                                status_next = bdq_pkg::STAT_EMPTY;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = bdq_pkg::slot_of(front_reg, count_reg,
                                                             rev_reg, '0);
                            end
                        end
                        bdq_pkg::OP_REVERSE: begin
                            if (empty) begin
                                status_next = bdq_pkg::STAT_EMPTY;
                            end else begin
                                rev_next = !rev_reg;
                            end
                        end
                        bdq_pkg::OP_CLEAR: begin
                            front_next = '0;
                            count_next = '0;
                            rev_next   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bdq_pkg::S_SCAN: begin
                // fetch the next entry ahead; a remove reuses it as the first shift source
                ram_re    = more;
                ram_raddr = bdq_pkg::slot_of(front_reg, count_reg, rev_reg, idx_inc);
                if (hit) begin
                    found_next = 1'b1;
                    pos_next   = idx_reg[IDX_W-1:0];
                    if (op_reg == bdq_pkg::OP_REMOVE && !more) begin
                        count_next = count_reg - CNT_W'(1);
                        if (rev_reg) begin
                            front_next = front_inc;
                        end
                    end
                end else if (more) begin
                    idx_next = idx_inc;
                end
            end
            bdq_pkg::S_SHIFT: begin
                // entry idx+1 is in the read register, move it down to idx
                ram_we    = 1'b1;
                ram_waddr = bdq_pkg::slot_of(front_reg, count_reg, rev_reg, idx_reg);
                ram_wdata = ram_rdata;
                if (shift_more) begin
                    ram_re    = 1'b1;
                    ram_raddr = bdq_pkg::slot_of(front_reg, count_reg, rev_reg,
                                                 idx_inc2[CNT_W-1:0]);
                    idx_next  = idx_inc;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    if (rev_reg) begin
                        front_next = front_inc;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bdq_pkg::S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            rev_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        data_reg    <= data_next;
        status_reg  <= status_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        found_reg   <= found_next;
        take_rd_reg <= take_rd_next;
        if (out_load) begin
            m_read_word_reg <= take_rd_reg ? ram_rdata : '0;
            m_status_reg    <= status_reg;
            m_found_reg     <= found_reg;
            m_position_reg  <= found_reg ? pos_reg : '0;
            m_occupancy_reg <= count_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_word = m_read_word_reg;
    assign m_status    = m_status_reg;
    assign m_found     = m_found_reg;
    assign m_position  = m_position_reg;
    assign m_occupancy = m_occupancy_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(bdq_pkg::CAPACITY))
        else $error("occupancy above capacity");

    a_full_push_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && full && (op_in == bdq_pkg::OP_PUSH_BACK ||
                            op_in == bdq_pkg::OP_PUSH_FRONT))
        |=> ($stable(count_reg) && $stable(front_reg)))
        else $error("refused push changed the queue");

    a_shift_only_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bdq_pkg::S_SHIFT) |-> (found_reg && op_reg == bdq_pkg::OP_REMOVE))
        else $error("shift without a remove hit");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bdq_pkg::S_SCAN || state_reg == bdq_pkg::S_SHIFT)
        |-> (idx_reg < count_reg))
        else $error("walk index outside the occupied range");
`endif

endmodule
